FILE: hdl/dbcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcr_pkg: shared types and constants for the cell raster block
// Codes, register resets, field widths and the geometry sequencer types.
// ----------------------------------------------------------------------------
package dbcr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIM_REG_W  = 13;
  localparam int unsigned CS_W       = 7;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 12;

  localparam logic [DIM_REG_W-1:0] FW_RESET = 13'd1920;
  localparam logic [DIM_REG_W-1:0] FH_RESET = 13'd1080;
  localparam logic [CS_W-1:0]      CS_RESET = 7'd8;
  localparam logic [CS_W-1:0]      CS_MAX   = 7'd64;
  localparam logic [CS_W-1:0]      CS_MIN   = 7'd1;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CELL_SIZE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    GEOM_IDLE,
    GEOM_COLS,
    GEOM_ROWS,
    GEOM_X,
    GEOM_Y,
    GEOM_MUL,
    GEOM_DONE
  } geom_state_e;

  typedef struct packed {
    logic busy;
    logic load;
  } geom_stat_t;

endpackage

FILE: hdl/dbcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcr_ram: generic single-clock RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module dbcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dbcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcr_div: restoring divider by the cell size
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
module dbcr_div #(
  parameter int unsigned DW = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DW-1:0]          dividend_i,
  input  logic [dbcr_pkg::CS_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DW-1:0]          quot_o,
  output logic [dbcr_pkg::CS_W-1:0] rem_o
);
  import dbcr_pkg::*;

  localparam int unsigned CNTW = $clog2(DW);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [CS_W-1:0] rem_q, rem_d;
  logic [CS_W-1:0] dvs_q, dvs_d;
  logic [CS_W:0]   trial;
  logic [CS_W:0]   diff;
  logic            ge;

  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[CS_W-1:0] : trial[CS_W-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/dbcr_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcr_geom: cell grid geometry sequencer
// Derives grid size and the cell position of the raster after a setting change.
// ----------------------------------------------------------------------------
module dbcr_geom #(
  parameter int unsigned CW = 12,
  localparam int unsigned DW = CW + 1,
  localparam int unsigned BW = 2 * CW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      kick_i,
  input  logic [DW-1:0]             fw_i,
  input  logic [DW-1:0]             fh_i,
  input  logic [dbcr_pkg::CS_W-1:0] cs_i,
  input  logic [CW-1:0]             raster_x_i,
  input  logic [CW-1:0]             raster_y_i,
  output dbcr_pkg::geom_stat_t      stat_o,
  output logic [DW-1:0]             cols_o,
  output logic [DW-1:0]             rows_o,
  output logic [DW-1:0]             cell_col_o,
  output logic [dbcr_pkg::CS_W-1:0] sub_x_o,
  output logic [DW-1:0]             cell_row_o,
  output logic [dbcr_pkg::CS_W-1:0] sub_y_o,
  output logic [BW-1:0]             row_base_o
);
  import dbcr_pkg::*;

  geom_state_e     state_q, state_d;
  logic            div_start;
  logic [DW-1:0]   div_dividend;
  logic            div_done;
  logic [DW-1:0]   div_quot;
  logic [CS_W-1:0] div_rem;

  logic [DW-1:0]   cols_q, rows_q, cell_col_q, cell_row_q;
  logic [CS_W-1:0] sub_x_q, sub_y_q;
  logic [BW-1:0]   row_base_q;

  dbcr_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cs_i),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEOM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = fw_i;
    stat_o.load  = 1'b0;
    if (kick_i) begin
      state_d   = GEOM_COLS;
      div_start = 1'b1;
    end else begin
      unique case (state_q)
        GEOM_IDLE: ;
        GEOM_COLS: if (div_done) begin
          state_d      = GEOM_ROWS;
          div_start    = 1'b1;
          div_dividend = fh_i;
        end
        GEOM_ROWS: if (div_done) begin
          state_d      = GEOM_X;
          div_start    = 1'b1;
          div_dividend = DW'(raster_x_i);
        end
        GEOM_X: if (div_done) begin
          state_d      = GEOM_Y;
          div_start    = 1'b1;
          div_dividend = DW'(raster_y_i);
        end
        GEOM_Y: if (div_done) begin
          state_d = GEOM_MUL;
        end
        GEOM_MUL: state_d = GEOM_DONE;
        GEOM_DONE: begin
          state_d     = GEOM_IDLE;
          stat_o.load = 1'b1;
        end
        default: state_d = GEOM_IDLE;
      endcase
    end
    stat_o.busy = (state_q != GEOM_IDLE);
  end

  always_ff @(posedge clk_i) begin
    if (div_done && state_q == GEOM_COLS) begin
      cols_q <= div_quot;
    end
    if (div_done && state_q == GEOM_ROWS) begin
      rows_q <= div_quot;
    end
    if (div_done && state_q == GEOM_X) begin
      cell_col_q <= div_quot;
      sub_x_q    <= div_rem;
    end
    if (div_done && state_q == GEOM_Y) begin
      cell_row_q <= div_quot;
      sub_y_q    <= div_rem;
    end
    if (state_q == GEOM_MUL) begin
      row_base_q <= BW'(cell_row_q * cols_q);
    end
  end

  assign cols_o     = cols_q;
  assign rows_o     = rows_q;
  assign cell_col_o = cell_col_q;
  assign sub_x_o    = sub_x_q;
  assign cell_row_o = cell_row_q;
  assign sub_y_o    = sub_y_q;
  assign row_base_o = row_base_q;

endmodule

FILE: hdl/data_bits_to_cell_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// data_bits_to_cell_raster: data bytes shown as a raster of grey cells
// Loads a frame's bytes into a byte RAM, then emits one pixel per request.
// ----------------------------------------------------------------------------
// A load (tuser 0) writes one byte; a pixel request (tuser 1) is taken every
// cycle unless the block is busy or the output stalls, and its pixel passes
// the byte RAM read as one stage and the output register as the next. Cell
// position is kept by raster counters, so no division sits in the pixel path.
// After reset and after every settings write the block drops tready while one
// shared divider works out the grid size and the cell position of the current
// raster point. Loads that find the store full or the raster away from its
// origin are dropped.
module data_bits_to_cell_raster #(
  parameter int unsigned STORE_BYTES = 65536,
  parameter int unsigned MAX_DIM     = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dbcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dbcr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte[7:0]
  input  logic                            s_axis_tuser,  // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_value[7:0], pixel_x[19:8], pixel_y[31:20]
  output logic [31:0]                     m_axis_tdata,
  output logic                            m_axis_tlast   // frame_end
);
  import dbcr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned BW = 2 * CW + 2;
  localparam int unsigned LW = $clog2(STORE_BYTES + 1);
  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned IW = ((BW - 3) > LW) ? (BW - 3) : LW;
  localparam logic [DW-1:0] MaxDimC = DW'(MAX_DIM);

  logic [DIM_REG_W-1:0] fw_q, fh_q;
  logic [CS_W-1:0]      cs_q;
  logic [DW-1:0]        fw_c, fh_c;
  logic [CS_W-1:0]      cs_c;
  logic                 kick_q;

  geom_stat_t           geom_stat;
  logic [DW-1:0]        cols, rows, g_cell_col, g_cell_row;
  logic [CS_W-1:0]      g_sub_x, g_sub_y;
  logic [BW-1:0]        g_row_base;
  logic                 busy;

  logic [CW-1:0]        x_q, x_d, y_q, y_d;
  logic [DW-1:0]        cell_col_q, cell_col_d, cell_row_q, cell_row_d;
  logic [CS_W-1:0]      sub_x_q, sub_x_d, sub_y_q, sub_y_d;
  logic [BW-1:0]        row_base_q, row_base_d;
  logic [LW-1:0]        bytes_q, bytes_d;

  logic                 in_acc, pix_acc, load_ok;
  logic                 line_end, last, in_grid, hit;
  logic [BW-1:0]        bit_idx;
  logic [BW-4:0]        byte_idx;
  logic [PIX_W-1:0]     rd_data;

  logic                 s1_v_q, s1_hit_q, s1_last_q;
  logic [2:0]           s1_sel_q;
  logic [COORD_W-1:0]   s1_x_q, s1_y_q;
  logic                 out_v_q, out_last_q;
  logic [PIX_W-1:0]     out_pix_q;
  logic [COORD_W-1:0]   out_x_q, out_y_q;
  logic                 out_free, s1_adv;

  // settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_RESET;
      fh_q   <= FH_RESET;
      cs_q   <= CS_RESET;
      kick_q <= 1'b1;
    end else begin
      kick_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
          CFG_CELL_SIZE:    cs_q <= cfg_data_i[CS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (fw_q == '0) fw_c = DW'(1);
    else if (32'(fw_q) > 32'(MAX_DIM)) fw_c = MaxDimC;
    else fw_c = DW'(fw_q);
    if (fh_q == '0) fh_c = DW'(1);
    else if (32'(fh_q) > 32'(MAX_DIM)) fh_c = MaxDimC;
    else fh_c = DW'(fh_q);
    if (cs_q == '0) cs_c = CS_MIN;
    else if (cs_q > CS_MAX) cs_c = CS_MAX;
    else cs_c = cs_q;
  end

  dbcr_geom #(
    .CW(CW)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kick_i     (kick_q),
    .fw_i       (fw_c),
    .fh_i       (fh_c),
    .cs_i       (cs_c),
    .raster_x_i (x_q),
    .raster_y_i (y_q),
    .stat_o     (geom_stat),
    .cols_o     (cols),
    .rows_o     (rows),
    .cell_col_o (g_cell_col),
    .sub_x_o    (g_sub_x),
    .cell_row_o (g_cell_row),
    .sub_y_o    (g_sub_y),
    .row_base_o (g_row_base)
  );

  assign busy     = kick_q || geom_stat.busy;
  assign out_free = !out_v_q || m_axis_tready;
  assign s1_adv   = s1_v_q && out_free;

  assign s_axis_tready = !busy && (!s1_v_q || out_free);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pix_acc       = in_acc && (s_axis_tuser == FUNC_PIXEL);
  assign load_ok       = in_acc && (s_axis_tuser == FUNC_LOAD) && (x_q == '0) &&
                         (y_q == '0) && (bytes_q < LW'(STORE_BYTES));

  assign line_end = DW'(x_q) >= (fw_c - DW'(1));
  assign last     = line_end && (DW'(y_q) >= (fh_c - DW'(1)));
  assign in_grid  = (cell_col_q < cols) && (cell_row_q < rows);
  assign bit_idx  = row_base_q + BW'(cell_col_q);
  assign byte_idx = bit_idx[BW-1:3];
  assign hit      = in_grid && (IW'(byte_idx) < IW'(bytes_q));

  // a load only lands at the raster origin, and one beat is either a load or a
  // pixel request, so a read never meets a write to the same entry in one cycle
  dbcr_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (AW'(bytes_q)),
    .wdata_i (s_axis_tdata),
    .re_i    (pix_acc),
    .raddr_i (AW'(byte_idx)),
    .rdata_o (rd_data)
  );

  // raster walk
  always_comb begin
    x_d        = x_q;
    y_d        = y_q;
    cell_col_d = cell_col_q;
    cell_row_d = cell_row_q;
    sub_x_d    = sub_x_q;
    sub_y_d    = sub_y_q;
    row_base_d = row_base_q;
    bytes_d    = bytes_q;
    if (geom_stat.load) begin
      cell_col_d = g_cell_col;
      cell_row_d = g_cell_row;
      sub_x_d    = g_sub_x;
      sub_y_d    = g_sub_y;
      row_base_d = g_row_base;
    end
    if (load_ok) begin
      bytes_d = bytes_q + LW'(1);
    end
    if (pix_acc) begin
      if (last) begin
        x_d        = '0;
        y_d        = '0;
        cell_col_d = '0;
        cell_row_d = '0;
        sub_x_d    = '0;
        sub_y_d    = '0;
        row_base_d = '0;
        bytes_d    = '0;
      end else if (line_end) begin
        x_d        = '0;
        cell_col_d = '0;
        sub_x_d    = '0;
        y_d        = y_q + CW'(1);
        if (sub_y_q + CS_W'(1) == cs_c) begin
          sub_y_d    = '0;
          cell_row_d = cell_row_q + DW'(1);
          row_base_d = row_base_q + BW'(cols);
        end else begin
          sub_y_d = sub_y_q + CS_W'(1);
        end
      end else begin
        x_d = x_q + CW'(1);
        if (sub_x_q + CS_W'(1) == cs_c) begin
          sub_x_d    = '0;
          cell_col_d = cell_col_q + DW'(1);
        end else begin
          sub_x_d = sub_x_q + CS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      cell_col_q <= '0;
      cell_row_q <= '0;
      sub_x_q    <= '0;
      sub_y_q    <= '0;
      row_base_q <= '0;
      bytes_q    <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      x_q        <= x_d;
      y_q        <= y_d;
      cell_col_q <= cell_col_d;
      cell_row_q <= cell_row_d;
      sub_x_q    <= sub_x_d;
      sub_y_q    <= sub_y_d;
      row_base_q <= row_base_d;
      bytes_q    <= bytes_d;
      if (pix_acc) s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (s1_adv) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  // read stage and output register
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_hit_q  <= hit;
      s1_sel_q  <= bit_idx[2:0];
      s1_x_q    <= COORD_W'(x_q);
      s1_y_q    <= COORD_W'(y_q);
      s1_last_q <= last;
    end
    if (s1_adv) begin
      out_pix_q  <= (s1_hit_q && rd_data[3'd7 - s1_sel_q]) ? PIX_ON : PIX_OFF;
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_y_q, out_x_q, out_pix_q};
  assign m_axis_tlast  = out_last_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && last) |=> (x_q == '0 && y_q == '0 && bytes_q == '0))
    else $error("raster or byte count not cleared after frame end");

  a_sub_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (sub_x_q < cs_c))
    else $error("column phase out of cell range");

  a_sub_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (sub_y_q < cs_c))
    else $error("row phase out of cell range");

  a_pix_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == PIX_ON || m_axis_tdata[7:0] == PIX_OFF))
    else $error("pixel grey level neither black nor white");

endmodule
